// ===== rtl/core/cv3_pkg.sv =====
// Shared types and constants for the 3x3 zero-padded image filter.
// Used by the window cells and the top level; depends on nothing.
package cv3_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int COEF_SLOT   = 16;
	localparam int OUT_W       = 35;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_INDEX_W = 2;
	localparam int SIZE_W      = 11;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int COLSUM_W    = PROD_W + 2;
	localparam int TOTAL_W     = COLSUM_W + 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COEF_TOP,
		CFG_COEF_MID,
		CFG_COEF_BOTTOM,
		CFG_IMAGE_SIZE
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [COLSUM_W-1:0] colsum_t;
	typedef logic signed [TOTAL_W-1:0]  total_t;

	typedef logic [2:0][SAMPLE_W-1:0] col_t;
	typedef logic [2:0][COEF_W-1:0]   coef_col_t;

	typedef struct packed {
		logic    action;
		sample_t sample;
	} pix_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered_value;
		logic                    last_of_frame;
	} res_t;

	typedef struct packed {
		logic       produce;
		logic       last;
		logic [2:0] row_ok;
		logic [2:0] col_ok;
	} ctl_t;

endpackage

// ===== rtl/core/cv3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the two line stores of the filter.
module cv3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/cv3_cell.sv =====
// One column cell of the 3x3 window: holds three samples, passes them to its
// left neighbor on each shift, and forms the masked column sum. Uses cv3_pkg.
module cv3_cell (
	input  logic                clk,
	input  logic                en,
	input  logic                shift,
	input  cv3_pkg::col_t       col_in,
	output cv3_pkg::col_t       col_out,
	input  cv3_pkg::coef_col_t  coef,
	input  logic [2:0]          mask,
	output cv3_pkg::colsum_t    sum
);
	import cv3_pkg::*;

	col_t    col_q;
	coef_t   coef_s [3];
	sample_t samp_s [3];
	prod_t   prod_c [3];
	prod_t   prod_s3 [3];
	colsum_t sum_s4;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef_s[r] = coef[r];
			samp_s[r] = col_q[r];
			prod_c[r] = coef_s[r] * samp_s[r];
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s3[r] <= mask[r] ? prod_c[r] : '0;
			end
			sum_s4 <= COLSUM_W'(prod_s3[0]) + COLSUM_W'(prod_s3[1]) + COLSUM_W'(prod_s3[2]);
		end
	end

	assign col_out = col_q;
	assign sum     = sum_s4;

endmodule

// ===== rtl/core/conv3x3_zero_padded_filter_top.sv =====
// Top level of the streaming 3x3 zero-padded image filter.
// Depends on cv3_pkg, cv3_ram (line stores) and cv3_cell (window columns).
//
// Usage: pix carries one sample of a square N x N image per item in raster
// order (action 0), followed by N+1 drain items (action 1). res carries one
// filtered pixel per item, in raster order, with last_of_frame set on the
// bottom-right pixel. Items on both channels move on valid and ready.
// cfg writes a register by index: the three coefficient rows and the image
// size; writing the size restarts the frame. Configure only while idle.
// Throughput: one item per clock while pix_ready is high. The result for
// pixel (r,c) is caused by the item at raster position r*N+c+N+1 and passes
// through the line store read, the window shift, the product register, the
// column sum register and the output buffer before it is offered on res.
// The receiver may stall at will: a two-entry output buffer takes results,
// and pix_ready falls only once its second entry is occupied.
// Reset clears the position, the coefficients and the pipeline and sets the
// size to 1024; the line stores are not cleared and need no clearing pass.
module conv3x3_zero_padded_filter_top #(
	parameter int MAX_SIZE = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_ready,
	input  cv3_pkg::pix_t                        pix,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output cv3_pkg::res_t                        res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cv3_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [cv3_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import cv3_pkg::*;

	localparam int COL_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SZ_W  = $clog2(MAX_SIZE + 1);
	localparam int ROW_W = $clog2(MAX_SIZE + 2);

	logic [CFG_DATA_W-1:0] coef_q [3];
	logic [SIZE_W-1:0]     size_q;
	logic [ROW_W-1:0]      ir_q;
	logic [COL_W-1:0]      ic_q;

	logic [SZ_W-1:0]  n_eff;
	logic [ROW_W-1:0] n_c;
	logic [ROW_W-1:0] ic_c;
	logic             en;
	logic             accept;
	logic             c0_case;
	logic             norm_case;
	ctl_t             ctl_c;
	sample_t          val_c;

	logic             v_s1;
	ctl_t             ctl_s1;
	sample_t          val_s1;
	logic [COL_W-1:0] ic_s1;
	logic             v_s2;
	ctl_t             ctl_s2;
	logic             v_s3;
	logic             last_s3;
	logic             v_s4;
	logic             last_s4;

	logic [SAMPLE_W-1:0] up_rd;
	logic [SAMPLE_W-1:0] mid_rd;
	col_t                new_col;
	col_t                cell_in [3];
	col_t                cell_out [3];
	coef_col_t           cell_coef [3];
	colsum_t             cell_sum [3];
	logic [2:0]          cell_mask [3];
	logic                shift;

	total_t total_c;
	res_t   push_data;
	logic   push;
	logic   pop;
	logic   out_valid_q;
	res_t   out_data_q;
	logic   skid_valid_q;
	res_t   skid_data_q;

	always_comb begin
		if (size_q == '0) begin
			n_eff = SZ_W'(1);
		end else if (32'(size_q) > MAX_SIZE) begin
			n_eff = SZ_W'(MAX_SIZE);
		end else begin
			n_eff = SZ_W'(size_q);
		end
	end

	assign n_c       = ROW_W'(n_eff);
	assign ic_c      = ROW_W'(ic_q);
	assign en        = !skid_valid_q;
	assign pix_ready = en;
	assign accept    = pix_valid && en;
	assign cfg_ready = 1'b1;
	assign val_c     = pix.action ? '0 : pix.sample;

	// A row-start item finishes the last pixel of the row two back; any other
	// item inside the frame finishes the pixel one row up and one column left.
	assign c0_case   = (ic_q == '0) && (ir_q >= ROW_W'(2));
	assign norm_case = (ic_q != '0) && (ir_q != '0);

	always_comb begin
		ctl_c.produce   = c0_case || norm_case;
		ctl_c.last      = c0_case && (ir_q == n_c + ROW_W'(1));
		ctl_c.row_ok[1] = 1'b1;
		ctl_c.col_ok[1] = 1'b1;
		if (c0_case) begin
			ctl_c.row_ok[0] = ir_q >= ROW_W'(3);
			ctl_c.row_ok[2] = ir_q <= n_c;
			ctl_c.col_ok[0] = n_c >= ROW_W'(2);
			ctl_c.col_ok[2] = 1'b0;
		end else begin
			ctl_c.row_ok[0] = ir_q >= ROW_W'(2);
			ctl_c.row_ok[2] = ir_q < n_c;
			ctl_c.col_ok[0] = ic_c >= ROW_W'(2);
			ctl_c.col_ok[2] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= '0;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			size_q    <= SIZE_RESET;
			ir_q      <= '0;
			ic_q      <= '0;
		end else begin
			if (accept) begin
				if (ir_q >= n_c + ROW_W'(1)) begin
					ir_q <= '0;
					ic_q <= '0;
				end else if (ic_c + ROW_W'(1) == n_c) begin
					ic_q <= '0;
					ir_q <= ir_q + ROW_W'(1);
				end else begin
					ic_q <= ic_q + COL_W'(1);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_COEF_TOP: begin
						coef_q[0] <= cfg_data;
					end
					CFG_COEF_MID: begin
						coef_q[1] <= cfg_data;
					end
					CFG_COEF_BOTTOM: begin
						coef_q[2] <= cfg_data;
					end
					CFG_IMAGE_SIZE: begin
						size_q <= cfg_data[SIZE_W-1:0];
						ir_q   <= '0;
						ic_q   <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			last_s3 <= 1'b0;
			last_s4 <= 1'b0;
		end else if (en) begin
			v_s1    <= accept;
			ctl_s1  <= ctl_c;
			v_s2    <= v_s1 && ctl_s1.produce;
			ctl_s2  <= ctl_s1;
			v_s3    <= v_s2;
			last_s3 <= ctl_s2.last;
			v_s4    <= v_s3;
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1 <= val_c;
			ic_s1  <= ic_q;
		end
	end

	cv3_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SIZE)
	) u_line_upper (
		.clk   (clk),
		.we    (shift),
		.waddr (ic_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (ic_q),
		.rdata (up_rd)
	);

	cv3_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SIZE)
	) u_line_middle (
		.clk   (clk),
		.we    (accept),
		.waddr (ic_q),
		.wdata (val_c),
		.re    (accept),
		.raddr (ic_q),
		.rdata (mid_rd)
	);

	assign shift      = en && v_s1;
	assign new_col[0] = up_rd;
	assign new_col[1] = mid_rd;
	assign new_col[2] = val_s1;

	for (genvar k = 0; k < 3; k++) begin : g_cell
		if (k == 2) begin : g_head
			assign cell_in[k] = new_col;
		end else begin : g_link
			assign cell_in[k] = cell_out[k+1];
		end
		for (genvar r = 0; r < 3; r++) begin : g_row
			assign cell_coef[k][r] = coef_q[r][COEF_SLOT*(2-k) +: COEF_W];
			assign cell_mask[k][r] = ctl_s2.row_ok[r] && ctl_s2.col_ok[k];
		end
		cv3_cell u_cell (
			.clk     (clk),
			.en      (en),
			.shift   (shift),
			.col_in  (cell_in[k]),
			.col_out (cell_out[k]),
			.coef    (cell_coef[k]),
			.mask    (cell_mask[k]),
			.sum     (cell_sum[k])
		);
	end

	assign total_c = TOTAL_W'(cell_sum[0]) + TOTAL_W'(cell_sum[1]) + TOTAL_W'(cell_sum[2]);
	assign push_data.filtered_value = OUT_W'(total_c);
	assign push_data.last_of_frame  = last_s4;
	assign push = en && v_s4;
	assign pop  = out_valid_q && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_data_q;

`ifndef ASSERT_OFF
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("second output entry is occupied while the first is empty");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en) |=> (v_s4 && $stable(last_s4)))
		else $error("result in the last stage was lost during a stall");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ic_c < n_c)
		else $error("column position is outside the image");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ir_q <= n_c + ROW_W'(1))
		else $error("row position is past the drain row");
`endif

endmodule
